@@ src/mf3_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types and constants of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 2048;
   localparam int NUM_BANKS          = 2;
   localparam int WIN_COLS           = 3;

   localparam int FRAME_WIDTH_W      = 12;
   localparam int FRAME_HEIGHT_W     = 16;
   localparam int CSR_DATA_W         = 16;
   localparam int CSR_INDEX_W        = 1;

   localparam int FRAME_WIDTH_RESET  = 640;
   localparam int FRAME_HEIGHT_RESET = 480;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   typedef logic [7:0] pixel_type;

   typedef enum logic {
      ACT_PIXEL = 1'b0,
      ACT_FLUSH = 1'b1
   } action_type;

   typedef struct packed {
      action_type action;
      pixel_type  pixel_in;
   } req_payload_type;

   typedef struct packed {
      pixel_type median_out;
      logic      frame_end;
   } rsp_payload_type;

   // one window column, top to bottom
   typedef struct packed {
      pixel_type top;
      pixel_type mid;
      pixel_type bot;
   } col_type;

   // window column index, oldest to newest
   typedef logic [1:0] win_sel_type;
   localparam win_sel_type WIN_OLD = 2'd0;
   localparam win_sel_type WIN_CTR = 2'd1;
   localparam win_sel_type WIN_NEW = 2'd2;

   // command from the request stage to the window stage
   typedef struct packed {
      logic        out;        // produces a result
      logic        use_old;    // median from the window before update
      win_sel_type left_sel;   // left column of the median
      logic        shift;      // shift a new column in
      logic        load;       // load a full drain window
      logic        upper_bank; // bank holding the upper row
      logic        top_mem;    // top from memory, else replicate mid
      logic        mid_mem;    // mid from memory, else replicate pixel
      logic        bot_px;     // bottom is the request pixel, else mid
      logic        frame_end;
      pixel_type   pixel;
   } stage_cmd_type;

endpackage

@@ src/mf3_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_if
// Valid/ready stream interfaces for pixel requests and median results.
// ----------------------------------------------------------------------------
interface mf3_req_if
   import mf3_pkg::*;
();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mf3_rsp_if
   import mf3_pkg::*;
();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ src/mf3_lbuf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_lbuf
// Line buffer bank: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mf3_lbuf
   import mf3_pkg::*;
#(
   parameter  int DEPTH  = MAX_WIDTH_DEFAULT,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  pixel_type         wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output pixel_type         rd_data_a,
   output pixel_type         rd_data_b
);

   pixel_type mem [DEPTH];
   pixel_type rd_a_ff;
   pixel_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ src/mf3_median.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_median
// Nine-input median by a fixed 19-element compare-exchange network.
// ----------------------------------------------------------------------------
module mf3_median
   import mf3_pkg::*;
(
   input  pixel_type [8:0] vals,
   output pixel_type       median
);

   localparam int NET_LEN = 19;
   localparam logic [3:0] NET_A [NET_LEN] = '{
      4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
      4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4
   };
   localparam logic [3:0] NET_B [NET_LEN] = '{
      4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
      4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2
   };
   localparam logic [3:0] MID_RANK = 4'd4;

   always_comb begin
      pixel_type [8:0] v;
      pixel_type       lo;
      pixel_type       hi;
      v = vals;
      for (int k = 0; k < NET_LEN; k++) begin
         lo = v[NET_A[k]];
         hi = v[NET_B[k]];
         if (lo > hi) begin
            v[NET_A[k]] = hi;
            v[NET_B[k]] = lo;
         end
      end
      median = v[MID_RANK];
   end

endmodule

@@ src/mf3_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_seq
// Request stage: frame config, raster and drain counters, line buffer
// addressing and the command for the window stage.
// ----------------------------------------------------------------------------
module mf3_seq
   import mf3_pkg::*;
#(
   parameter  int MAX_WIDTH = MAX_WIDTH_DEFAULT,
   localparam int COL_W     = $clog2(MAX_WIDTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   req_valid,
   input  req_payload_type        req_payload,
   input  logic                   take,
   output logic                   cmd_valid,
   output stage_cmd_type          cmd,
   output logic                   rd_en,
   output logic [COL_W-1:0]       rd_addr_a,
   output logic [COL_W-1:0]       rd_addr_b,
   output logic [NUM_BANKS-1:0]   wr_en,
   output logic [COL_W-1:0]       wr_addr,
   output pixel_type              wr_data
);

   localparam int CNT_W = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W = (CNT_W > FRAME_WIDTH_W) ? CNT_W : FRAME_WIDTH_W;
   localparam int WIDTH_CLAMP = (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                : FRAME_WIDTH_RESET;
   localparam logic [COL_W-1:0] WIDTH_M1_RESET = COL_W'(WIDTH_CLAMP - 1);
   localparam logic [FRAME_HEIGHT_W-1:0] HEIGHT_M1_RESET =
      FRAME_HEIGHT_W'(FRAME_HEIGHT_RESET - 1);

   logic [COL_W-1:0]          width_m1_ff, width_m1_in;
   logic [FRAME_HEIGHT_W-1:0] height_m1_ff, height_m1_in;
   logic [COL_W-1:0]          col_ff, col_in;
   logic [FRAME_HEIGHT_W-1:0] row_ff, row_in;
   logic                      drain_ff, drain_in;
   logic                      extra_ff, extra_in;
   logic [COL_W-1:0]          dcol_ff, dcol_in;
   logic                      last_par_ff, last_par_in;

   logic [CMP_W-1:0]          w_raw;
   logic [CMP_W-1:0]          w_eff;
   logic [COL_W-1:0]          width_m1_new;
   logic [FRAME_HEIGHT_W-1:0] h_raw;
   logic [FRAME_HEIGHT_W-1:0] height_m1_new;

   logic        wide, tall;
   logic        acc, is_flush, pix_go, fl_go;
   logic        col_last, row_last, dcol_last;
   logic        row_ge1, row_ge2;
   win_sel_type rim_sel;
   logic [COL_W-1:0] drain_addr;

   // effective frame size, clamped at write time
   assign w_raw = CMP_W'(csr_write_data[FRAME_WIDTH_W-1:0]);
   assign w_eff = (w_raw == '0) ? CMP_W'(1)
                : ((w_raw > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : w_raw);
   assign width_m1_new  = COL_W'(w_eff - CMP_W'(1));
   assign h_raw         = csr_write_data[FRAME_HEIGHT_W-1:0];
   assign height_m1_new = (h_raw == '0) ? '0 : (h_raw - FRAME_HEIGHT_W'(1));

   assign wide = (width_m1_ff != '0);
   assign tall = (height_m1_ff != '0);

   assign acc       = req_valid && take;
   assign is_flush  = (req_payload.action == ACT_FLUSH);
   assign pix_go    = acc && !is_flush && !drain_ff;
   assign fl_go     = acc && is_flush && drain_ff;
   assign col_last  = (col_ff == width_m1_ff);
   assign row_last  = (row_ff == height_m1_ff);
   assign dcol_last = (dcol_ff == width_m1_ff);
   assign row_ge1   = (row_ff != '0);
   assign row_ge2   = (row_ff[FRAME_HEIGHT_W-1:1] != '0);
   assign rim_sel   = wide ? WIN_CTR : WIN_NEW;
   assign drain_addr = dcol_last ? dcol_ff : (dcol_ff + COL_W'(1));

   always_comb begin
      width_m1_in  = width_m1_ff;
      height_m1_in = height_m1_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      drain_in     = drain_ff;
      extra_in     = extra_ff;
      dcol_in      = dcol_ff;
      last_par_in  = last_par_ff;
      if (csr_write_enable) begin
         col_in   = '0;
         row_in   = '0;
         drain_in = 1'b0;
         extra_in = 1'b0;
         dcol_in  = '0;
         case (csr_index)
            CSR_FRAME_WIDTH:  width_m1_in  = width_m1_new;
            CSR_FRAME_HEIGHT: height_m1_in = height_m1_new;
            default: ;
         endcase
      end else if (pix_go) begin
         if (col_last) begin
            col_in = '0;
            if (row_last) begin
               row_in      = '0;
               drain_in    = 1'b1;
               extra_in    = tall;
               dcol_in     = '0;
               last_par_in = row_ff[0];
            end else begin
               row_in = row_ff + FRAME_HEIGHT_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end else if (fl_go) begin
         if (extra_ff) begin
            extra_in = 1'b0;
         end else if (dcol_last) begin
            drain_in = 1'b0;
            dcol_in  = '0;
         end else begin
            dcol_in = dcol_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_m1_ff  <= WIDTH_M1_RESET;
         height_m1_ff <= HEIGHT_M1_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         drain_ff     <= 1'b0;
         extra_ff     <= 1'b0;
         dcol_ff      <= '0;
         last_par_ff  <= 1'b0;
      end else begin
         width_m1_ff  <= width_m1_in;
         height_m1_ff <= height_m1_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         drain_ff     <= drain_in;
         extra_ff     <= extra_in;
         dcol_ff      <= dcol_in;
         last_par_ff  <= last_par_in;
      end
   end

   always_comb begin
      cmd       = '0;
      cmd.pixel = req_payload.pixel_in;
      if (drain_ff) begin
         cmd.out = 1'b1;
         if (extra_ff) begin
            // right edge of the row before last, from the held window
            cmd.use_old  = 1'b1;
            cmd.left_sel = rim_sel;
         end else begin
            cmd.left_sel   = WIN_OLD;
            cmd.load       = (dcol_ff == '0);
            cmd.shift      = (dcol_ff != '0);
            cmd.upper_bank = !last_par_ff;
            cmd.top_mem    = tall;
            cmd.mid_mem    = 1'b1;
            cmd.frame_end  = dcol_last;
         end
      end else begin
         cmd.shift      = 1'b1;
         cmd.upper_bank = row_ff[0];
         cmd.top_mem    = row_ge2;
         cmd.mid_mem    = row_ge1;
         cmd.bot_px     = 1'b1;
         if (col_ff == '0) begin
            cmd.out      = row_ge2;
            cmd.use_old  = 1'b1;
            cmd.left_sel = rim_sel;
         end else begin
            cmd.out      = row_ge1;
            cmd.left_sel = (col_ff == COL_W'(1)) ? WIN_CTR : WIN_OLD;
         end
      end
   end

   assign cmd_valid = pix_go || fl_go;

   // even rows live in bank 0, odd rows in bank 1
   assign rd_en     = acc;
   assign rd_addr_a = drain_ff ? drain_addr : col_ff;
   assign rd_addr_b = '0;
   assign wr_en[0]  = pix_go && !row_ff[0];
   assign wr_en[1]  = pix_go && row_ff[0];
   assign wr_addr   = col_ff;
   assign wr_data   = req_payload.pixel_in;

   a_extra_in_drain: assert property (@(posedge clock) disable iff (reset)
      extra_ff |-> drain_ff)
      else $error("edge result pending outside drain");

   a_drain_counters: assert property (@(posedge clock) disable iff (reset)
      drain_ff |-> (col_ff == '0 && row_ff == '0))
      else $error("raster counters not at frame start during drain");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= width_m1_ff) && (dcol_ff <= width_m1_ff))
      else $error("column counter beyond frame width");

endmodule

@@ src/mf3_win.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_win
// Window stage: 3x3 window update from line buffer data, median network
// and the result register.
// ----------------------------------------------------------------------------
module mf3_win
   import mf3_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   input  stage_cmd_type              cmd,
   output logic                       take,
   input  pixel_type [NUM_BANKS-1:0]  rd_a,
   input  pixel_type [NUM_BANKS-1:0]  rd_b,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_payload_type            rsp_payload
);

   logic                       s1_valid_ff, s1_valid_in;
   stage_cmd_type              cmd_ff;
   col_type [WIN_COLS-1:0]     win_ff, win_next;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_payload_type            rsp_data_ff;

   logic                   s1_go;
   pixel_type              up_a, mid_a, up_b, mid_b;
   pixel_type              mid_v, top_v, bot_v, top0;
   col_type                new_col, col0;
   col_type [WIN_COLS-1:0] src;
   col_type                left_col, ctr_col, right_col;
   pixel_type [8:0]        med_in;
   pixel_type              med_out;

   assign s1_go = s1_valid_ff && (!cmd_ff.out || !rsp_valid_ff || rsp_ready);
   assign take  = !s1_valid_ff || s1_go;

   assign up_a  = rd_a[cmd_ff.upper_bank];
   assign mid_a = rd_a[!cmd_ff.upper_bank];
   assign up_b  = rd_b[cmd_ff.upper_bank];
   assign mid_b = rd_b[!cmd_ff.upper_bank];

   // missing rows replicate the nearest one
   assign mid_v   = cmd_ff.mid_mem ? mid_a : cmd_ff.pixel;
   assign top_v   = cmd_ff.top_mem ? up_a : mid_v;
   assign bot_v   = cmd_ff.bot_px ? cmd_ff.pixel : mid_v;
   assign new_col = '{top: top_v, mid: mid_v, bot: bot_v};
   assign top0    = cmd_ff.top_mem ? up_b : mid_b;
   assign col0    = '{top: top0, mid: mid_b, bot: mid_b};

   always_comb begin
      if (cmd_ff.load) begin
         win_next = {new_col, col0, col0};
      end else if (cmd_ff.shift) begin
         win_next = {new_col, win_ff[2], win_ff[1]};
      end else begin
         win_next = win_ff;
      end
   end

   assign src = cmd_ff.use_old ? win_ff : win_next;

   always_comb begin
      case (cmd_ff.left_sel)
         WIN_OLD: left_col = src[0];
         WIN_CTR: left_col = src[1];
         default: left_col = src[2];
      endcase
   end

   assign ctr_col   = cmd_ff.use_old ? src[2] : src[1];
   assign right_col = src[2];
   assign med_in    = {left_col, ctr_col, right_col};

   mf3_median u_median (
      .vals   (med_in),
      .median (med_out)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (cmd_valid) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && cmd_ff.out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_valid) begin
         cmd_ff <= cmd;
      end
      if (s1_go) begin
         win_ff <= win_next;
      end
      if (s1_go && cmd_ff.out) begin
         rsp_data_ff.median_out <= med_out;
         rsp_data_ff.frame_end  <= cmd_ff.frame_end;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   a_cmd_into_free_stage: assert property (@(posedge clock) disable iff (reset)
      cmd_valid |-> take)
      else $error("command pushed into an occupied window stage");

   a_frame_end_from_drain: assert property (@(posedge clock) disable iff (reset)
      (s1_go && cmd_ff.frame_end) |-> (cmd_ff.out && !cmd_ff.use_old && !cmd_ff.bot_px))
      else $error("frame end marked outside the drain of the last row");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("result dropped or changed while stalled");

endmodule

@@ src/median_filter_3x3.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3
// Streaming 3x3 median filter for 8-bit pixels with edge replication.
//
//   channel  dir  handshake        payload
//   req      in   valid/ready      action, pixel_in
//   rsp      out  valid/ready      median_out, frame_end
//   csr      in   write enable     index, 16-bit write data
//
// One request per cycle while rsp is not stalled. A result is valid on rsp
// once the window stage passes on the request that completes its window: the
// line buffer read and the command are registered at the accepting edge, the
// window update and the compare-exchange network fill the result register.
// Results trail the pixels by one row plus one pixel; flush requests drain
// the last row. Reset clears the counters and restores the 640x480 frame
// size; line buffers are not cleared. A stalled rsp holds one result and the
// window stage one more, then req.ready drops. A csr write restarts the frame.
// ----------------------------------------------------------------------------
module median_filter_3x3
   import mf3_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   mf3_req_if.sink                req_chan,
   mf3_rsp_if.source              rsp_chan
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic                      take;
   logic                      cmd_valid;
   stage_cmd_type             cmd;
   logic                      rd_en;
   logic [COL_W-1:0]          rd_addr_a;
   logic [COL_W-1:0]          rd_addr_b;
   logic [NUM_BANKS-1:0]      wr_en;
   logic [COL_W-1:0]          wr_addr;
   pixel_type                 wr_data;
   pixel_type [NUM_BANKS-1:0] rd_a;
   pixel_type [NUM_BANKS-1:0] rd_b;

   mf3_seq #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_chan.valid),
      .req_payload      (req_chan.payload),
      .take             (take),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .rd_en            (rd_en),
      .rd_addr_a        (rd_addr_a),
      .rd_addr_b        (rd_addr_b),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data)
   );

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      mf3_lbuf #(
         .DEPTH (MAX_WIDTH)
      ) u_lbuf (
         .clock     (clock),
         .wr_en     (wr_en[b]),
         .wr_addr   (wr_addr),
         .wr_data   (wr_data),
         .rd_en     (rd_en),
         .rd_addr_a (rd_addr_a),
         .rd_addr_b (rd_addr_b),
         .rd_data_a (rd_a[b]),
         .rd_data_b (rd_b[b])
      );
   end

   mf3_win u_win (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .take        (take),
      .rd_a        (rd_a),
      .rd_b        (rd_b),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload)
   );

   assign req_chan.ready = take;

endmodule
